### src/agpd_pkg.sv
// ----------------------------------------------------------------------------
// agpd_pkg
// Shared types, constants and a helper function for the adaptive-gain PD
// balance controller.
// ----------------------------------------------------------------------------
`default_nettype none
package agpd_pkg;

  localparam int GAIN_WIDTH_DEF  = 12;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int TBL_DEPTH   = 45;
  localparam int TBL_AW      = 6;
  localparam int NUM_OPS     = 5;
  localparam int NUM_STATES  = 3;

  localparam logic [16:0] F_HALF    = 17'd32768;
  localparam logic [16:0] C_INIT    = 17'd655;
  localparam logic [15:0] C_DECAY   = 16'd64880;
  localparam logic [16:0] EXP_FLOOR = 17'd36044;

  localparam logic [1:0] CFG_PERIOD   = 2'd0;
  localparam logic [1:0] CFG_STABLE   = 2'd1;
  localparam logic [1:0] CFG_CRITICAL = 2'd2;
  localparam logic [1:0] CFG_EXPLORE  = 2'd3;

  localparam logic [2:0] OP_WAIT      = 3'd0;
  localparam logic [2:0] OP_ANGLE_UP  = 3'd1;
  localparam logic [2:0] OP_ANGLE_DN  = 3'd2;
  localparam logic [2:0] OP_RATE_UP   = 3'd3;
  localparam logic [2:0] OP_RATE_DN   = 3'd4;

  localparam logic [1:0] ST_STABLE   = 2'd0;
  localparam logic [1:0] ST_WARNING  = 2'd1;
  localparam logic [1:0] ST_CRITICAL = 2'd2;

  typedef struct packed {
    logic signed [15:0] cart_position;
    logic signed [15:0] cart_velocity;
    logic signed [15:0] pole_angle;
    logic signed [15:0] pole_rate;
    logic [15:0]        gate_draw;
    logic [15:0]        pick_draw;
  } in_item_t;

  typedef struct packed {
    logic        push_action;
    logic [15:0] gain_changes;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load_item;
    logic       classify;
    logic       rev_start;
    logic [1:0] rev_post;
    logic       rev_read;
    logic       rev_write;
    logic       scan_read;
    logic [2:0] scan_op;
    logic       scan_eval;
    logic       apply;
    logic       hist_write;
    logic       force_mul;
    logic       force_sum;
    logic       out_load;
  } agpd_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic       tick;
    logic       not_stable;
    logic       history_valid;
    logic       div_done;
  } agpd_sts_t;

  function automatic logic [TBL_AW-1:0] tbl_index(input logic [1:0] pre,
                                                  input logic [2:0] op,
                                                  input logic [1:0] post);
    logic [7:0] i;
    i = ({6'd0, pre} * 8'd5 + {5'd0, op}) * 8'd3 + {6'd0, post};
    tbl_index = (i < 8'(TBL_DEPTH)) ? i[TBL_AW-1:0] : '0;
  endfunction

endpackage
`default_nettype wire

### src/adaptive_gain_pd_balance_controller_unit.sv
// ----------------------------------------------------------------------------
// adaptive_gain_pd_balance_controller_unit
// Bang-bang PD balance controller with periodic state classification,
// truth-value learning and gain adjustment.
//
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_item_t
// out       output     out_valid/out_stall out_item_t
// cfg       input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A plain tick runs only force multiply, force sum and output load. A classifying
// decision tick with history adds three table revisions (read, load, wait on
// the divider, write) and a read-and-evaluate scan of the five operations;
// without history it skips the revisions. Both then apply before the force steps.
// One observation is in flight at a time; a new one is taken once the
// previous result has left the output register. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none
module adaptive_gain_pd_balance_controller_unit
  import agpd_pkg::*;
#(
  parameter int GAIN_WIDTH  = GAIN_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  agpd_cmd_t cmd;
  agpd_sts_t sts;

  assign cfg_ready = 1'b1;

  agpd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  agpd_datapath #(
    .GAIN_WIDTH  (GAIN_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_data)
  );

endmodule
`default_nettype wire

### src/agpd_ram.sv
// ----------------------------------------------------------------------------
// agpd_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module agpd_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 45
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

### src/agpd_div.sv
// ----------------------------------------------------------------------------
// agpd_div
// Restoring divider for the confidence update: 64880*65536 / (131072 - c),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module agpd_div
  import agpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] conf,
  output logic             done,
  output logic [15:0]      quot
);

  localparam int QB = 17;

  logic [17:0] divisor;
  logic [17:0] rem;
  logic [32:0] dividend;
  logic [QB-1:0] q;
  logic [5:0] count;
  logic busy;
  logic [18:0] trial;

  assign trial = {rem, dividend[32]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= 6'd33;
        divisor  <= 18'd131072 - {2'b00, conf};
        rem      <= '0;
        dividend <= {1'b0, C_DECAY, 16'd0};
        q        <= '0;
      end else if (busy) begin
        if (!trial[18]) begin
          rem <= trial[17:0];
          q   <= {q[QB-2:0], 1'b1};
        end else begin
          rem <= {rem[16:0], dividend[32]};
          q   <= {q[QB-2:0], 1'b0};
        end
        dividend <= {dividend[31:0], 1'b0};
        count    <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q[15:0];

endmodule
`default_nettype wire

### src/agpd_datapath.sv
// ----------------------------------------------------------------------------
// agpd_datapath
// Registers, truth table, arithmetic and gain state of the controller.
// ----------------------------------------------------------------------------
`default_nettype none
module agpd_datapath
  import agpd_pkg::*;
#(
  parameter int GAIN_WIDTH  = GAIN_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire in_item_t   in_item,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire agpd_cmd_t  cmd,
  output agpd_sts_t       sts,
  output out_item_t       out_item
);

  localparam logic [GAIN_WIDTH-1:0]  GMAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  logic [7:0]  cortex_period;
  logic [14:0] stable_limit;
  logic [14:0] critical_limit;
  logic [15:0] explore_rate;

  in_item_t item;
  logic [7:0] tick_phase;
  logic [1:0] prior_state;
  logic [2:0] prior_operation;
  logic       history_valid;
  logic [GAIN_WIDTH-1:0]  angle_gain;
  logic [GAIN_WIDTH-1:0]  rate_gain;
  logic [COUNT_WIDTH-1:0] change_count;
  logic [TBL_DEPTH-1:0]   tv_valid;

  logic       tick;
  logic [1:0] cur_state;
  logic [16:0] best;
  logic [2:0]  best_op;
  logic [2:0]  chosen_op;
  logic [2:0]  pick_op;

  logic [TBL_AW-1:0] ram_addr;
  logic              ram_we;
  logic [31:0]       ram_wdata;
  logic [31:0]       ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [15:0]       div_quot;
  logic [15:0]       rev_f;
  logic [15:0]       rev_c;
  logic [15:0]       load_f;
  logic [15:0]       load_c;
  logic [15:0]       new_f;
  logic [16:0]       exp_val;

  logic signed [20:0] lin_term;
  logic signed [20:0] rate_x20;
  logic signed [GAIN_WIDTH+21:0] prod_a;
  logic signed [GAIN_WIDTH+21:0] prod_r;
  logic signed [GAIN_WIDTH+22:0] force_sum;

  // Magnitude of the angle, with the most negative code giving 32768.
  logic [15:0] mag;
  assign mag = item.pole_angle[15] ? 16'(-item.pole_angle) : item.pole_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      cortex_period  <= 8'd5;
      stable_limit   <= 15'd82;
      critical_limit <= 15'd328;
      explore_rate   <= 16'd6554;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIOD:   cortex_period  <= cfg_data[7:0];
        CFG_STABLE:   stable_limit   <= cfg_data[14:0];
        CFG_CRITICAL: critical_limit <= cfg_data[14:0];
        CFG_EXPLORE:  explore_rate   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Revision arithmetic, done in a single stage after the entry is read.
  logic [31:0] fc_prod;
  logic [32:0] ev_term;
  logic [33:0] f_acc;
  logic        ev;
  assign ev      = (cmd.rev_post == cur_state);
  assign fc_prod = {16'd0, rev_f} * {16'd0, rev_c};
  assign ev_term = ev ? {17'd65536 - {1'b0, rev_c}, 16'd0} : 33'd0;
  assign f_acc   = {2'b00, fc_prod} + {1'b0, ev_term};
  assign new_f   = (f_acc[33:16] > 18'd65535) ? 16'hFFFF : f_acc[31:16];

  logic [31:0] ce_prod;
  logic [32:0] cf_prod;
  assign ce_prod = {16'd0, ram_rdata[15:0]} * {16'd0, ram_rdata[31:16]};
  assign cf_prod = ({16'd0, 17'd65536 - {1'b0, ram_rdata[15:0]}}) << 15;
  assign exp_val = 17'(({1'b0, ce_prod} + cf_prod) >> 16);

  always_comb begin
    ram_we    = cmd.rev_write;
    ram_wdata = {new_f, div_quot};
    if (cmd.rev_read || cmd.rev_start || cmd.rev_write) begin
      ram_addr = tbl_index(prior_state, prior_operation, cmd.rev_post);
    end else begin
      ram_addr = tbl_index(cur_state, cmd.scan_op, 2'd0);
    end
  end

  assign load_f = tv_valid[ram_addr] ? ram_rdata[31:16] : F_HALF[15:0];
  assign load_c = tv_valid[ram_addr] ? ram_rdata[15:0] : C_INIT[15:0];

  agpd_ram #(.WIDTH(32), .DEPTH(TBL_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign div_start = cmd.rev_start;

  agpd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .conf  (load_c),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign pick_op  = 3'(({16'd0, item.pick_draw} * 32'd5) >> 16);
  assign chosen_op = ((best <= EXP_FLOOR) || (item.gate_draw < explore_rate)) ? pick_op : best_op;

  assign lin_term = 21'(item.cart_position) + 21'(item.cart_velocity)
                    - 21'(item.pole_angle) * 21'sd20;
  assign rate_x20 = 21'(item.pole_rate) * 21'sd20;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_phase      <= '0;
      prior_state     <= ST_STABLE;
      prior_operation <= OP_WAIT;
      history_valid   <= 1'b0;
      angle_gain      <= GAIN_WIDTH'(1);
      rate_gain       <= '0;
      change_count    <= '0;
      tv_valid        <= '0;
      tick            <= 1'b0;
      cur_state       <= ST_STABLE;
    end else begin
      if (cmd.load_item) begin
        item <= in_item;
        if ({1'b0, tick_phase} + 9'd1 >= {1'b0, cortex_period}) begin
          tick       <= 1'b1;
          tick_phase <= '0;
        end else begin
          tick       <= 1'b0;
          tick_phase <= tick_phase + 8'd1;
        end
      end
      if (cmd.classify) begin
        cur_state <= (mag < {1'b0, stable_limit}) ? ST_STABLE :
                     (mag < {1'b0, critical_limit}) ? ST_WARNING : ST_CRITICAL;
        best      <= F_HALF;
        best_op   <= OP_WAIT;
      end
      if (cmd.rev_start) begin
        rev_f <= load_f;
        rev_c <= load_c;
      end
      if (cmd.rev_write) begin
        tv_valid[ram_addr] <= 1'b1;
      end
      if (cmd.scan_eval) begin
        if (tv_valid[ram_addr] && exp_val > best) begin
          best    <= exp_val;
          best_op <= cmd.scan_op;
        end
      end
      if (cmd.apply) begin
        case (chosen_op)
          OP_ANGLE_UP: angle_gain <= (angle_gain > GMAX - GAIN_WIDTH'(5)) ? GMAX
                                     : angle_gain + GAIN_WIDTH'(5);
          OP_ANGLE_DN: angle_gain <= (angle_gain < GAIN_WIDTH'(5)) ? '0
                                     : angle_gain - GAIN_WIDTH'(5);
          OP_RATE_UP:  rate_gain  <= (rate_gain == GMAX) ? GMAX : rate_gain + GAIN_WIDTH'(1);
          OP_RATE_DN:  rate_gain  <= (rate_gain == '0) ? '0 : rate_gain - GAIN_WIDTH'(1);
          default:     ;
        endcase
        if (chosen_op != OP_WAIT && change_count != CMAX) begin
          change_count <= change_count + COUNT_WIDTH'(1);
        end
        prior_state     <= cur_state;
        prior_operation <= chosen_op;
      end
      if (cmd.hist_write) begin
        if (cur_state == ST_STABLE) begin
          prior_state     <= ST_STABLE;
          prior_operation <= OP_WAIT;
        end
        history_valid <= 1'b1;
      end
      if (cmd.force_mul) begin
        prod_a <= $signed({1'b0, angle_gain}) * lin_term;
        prod_r <= $signed({1'b0, rate_gain}) * rate_x20;
      end
      if (cmd.force_sum) begin
        force_sum <= (GAIN_WIDTH+23)'(prod_a) - (GAIN_WIDTH+23)'(prod_r);
      end
      if (cmd.out_load) begin
        out_item.push_action  <= force_sum[GAIN_WIDTH+22];
        out_item.gain_changes <= (change_count > COUNT_WIDTH'(16'hFFFF)) ? 16'hFFFF
                                 : 16'(change_count);
      end
    end
  end

  assign sts.tick          = tick;
  assign sts.not_stable    = (cur_state != ST_STABLE);
  assign sts.history_valid = history_valid;
  assign sts.div_done      = div_done;

endmodule
`default_nettype wire

### src/agpd_ctrl.sv
// ----------------------------------------------------------------------------
// agpd_ctrl
// Per-observation sequencer: load, classify, revise, scan, apply, force, out.
// ----------------------------------------------------------------------------
`default_nettype none
module agpd_ctrl
  import agpd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire agpd_sts_t sts,
  output agpd_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLASSIFY, S_REV_READ, S_REV_LOAD, S_REV_DIV, S_REV_WRITE,
    S_SCAN_READ, S_SCAN_EVAL, S_APPLY, S_FORCE_MUL, S_FORCE_SUM, S_OUT
  } state_t;

  state_t     state;
  logic [1:0] post;
  logic [2:0] op;
  logic       out_full;

  assign in_stall  = (state != S_IDLE) || out_full;
  assign out_valid = out_full;

  always_comb begin
    cmd           = '0;
    cmd.rev_post  = post;
    cmd.scan_op   = op;
    case (state)
      S_IDLE:      cmd.load_item = in_valid && !out_full;
      S_CLASSIFY:  cmd.classify  = sts.tick;
      S_REV_READ:  cmd.rev_read  = 1'b1;
      S_REV_LOAD:  cmd.rev_start = 1'b1;
      S_REV_DIV:   cmd.rev_read  = 1'b1;
      S_REV_WRITE: cmd.rev_write = 1'b1;
      S_SCAN_READ: cmd.scan_read = 1'b1;
      S_SCAN_EVAL: cmd.scan_eval = 1'b1;
      S_APPLY: begin
        cmd.apply      = sts.not_stable;
        cmd.hist_write = 1'b1;
      end
      S_FORCE_MUL: cmd.force_mul = 1'b1;
      S_FORCE_SUM: cmd.force_sum = 1'b1;
      S_OUT:       cmd.out_load  = 1'b1;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      post     <= '0;
      op       <= '0;
      out_full <= 1'b0;
    end else begin
      if (out_full && !out_stall) begin
        out_full <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !out_full) begin
            state <= S_CLASSIFY;
          end
        end
        S_CLASSIFY: begin
          post <= '0;
          op   <= '0;
          if (!sts.tick) begin
            state <= S_FORCE_MUL;
          end else if (sts.history_valid) begin
            state <= S_REV_READ;
          end else begin
            state <= S_SCAN_READ;
          end
        end
        S_REV_READ:  state <= S_REV_LOAD;
        S_REV_LOAD:  state <= S_REV_DIV;
        S_REV_DIV: begin
          if (sts.div_done) begin
            state <= S_REV_WRITE;
          end
        end
        S_REV_WRITE: begin
          if (post == 2'd2) begin
            post  <= '0;
            state <= S_SCAN_READ;
          end else begin
            post  <= post + 2'd1;
            state <= S_REV_READ;
          end
        end
        S_SCAN_READ: state <= S_SCAN_EVAL;
        S_SCAN_EVAL: begin
          if (op == 3'(NUM_OPS - 1)) begin
            state <= S_APPLY;
          end else begin
            op    <= op + 3'd1;
            state <= S_SCAN_READ;
          end
        end
        S_APPLY:     state <= S_FORCE_MUL;
        S_FORCE_MUL: state <= S_FORCE_SUM;
        S_FORCE_SUM: state <= S_OUT;
        S_OUT: begin
          out_full <= 1'b1;
          state    <= S_IDLE;
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/agpd_checker.sv
// ----------------------------------------------------------------------------
// agpd_checker
// Port-level checks on the controller, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none
module agpd_checker
  import agpd_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Second transaction accepted while one is in flight.");

  a_wait_on_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("Input accepted while a result waits.");

  a_no_result_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("Result appeared in the cycle after acceptance.");

endmodule

bind adaptive_gain_pd_balance_controller_unit agpd_checker u_agpd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
